// File: sv/cqf_pkg.sv
// cqf_pkg: shared constants, types and helpers for the circular queue FIFO.
// No dependencies; imported by circular_queue_fifo.
package cqf_pkg;

  localparam int DEPTH  = 1024;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 11;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PADDR_W = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_DEQ    = 2'd1,
    FUNC_STATUS = 2'd2
  } func_t;

  // zero reads as one, anything above the built depth saturates
  function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CAP_W-1:0] raw);
    logic [31:0] c;
    c = 32'(raw);
    if (c == 32'd0) c = 32'd1;
    if (c > 32'(DEPTH)) c = 32'(DEPTH);
    return CNT_W'(c);
  endfunction

endpackage

// File: sv/circular_queue_fifo.sv
// circular_queue_fifo: ring-buffer queue of 32-bit words with run-time capacity.
// Depends on cqf_pkg and cqf_ram.
//
// Each accepted input word asks for an enqueue, a dequeue or a status report and
// yields exactly one result word: accepted flag, oldest and newest stored words
// (all ones when empty) and empty/full flags, all as of after the operation.
// Storage is one 1024 x 32 synchronous RAM; the newest and oldest words are
// also kept in registers so that only a dequeue needs a memory read. Enqueue,
// status, refused requests and a dequeue that empties the queue need no RAM
// read (next input can follow right behind); a dequeue that leaves entries
// passes through ST_READ, the RAM read of the new oldest word, and stalls input.
// The result sits in an output register, so a new input is taken in the same
// cycle the previous result is taken. Capacity (register 0, byte address 0)
// reads back clamped to 1..1024; writing it empties the queue. Write it only
// while no request is in flight. No clearing pass after reset.
module circular_queue_fifo
  import cqf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic signed [WORD_W-1:0]  in_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_accepted,
  output logic signed [WORD_W-1:0]  out_front_value,
  output logic signed [WORD_W-1:0]  out_rear_value,
  output logic                      out_is_empty,
  output logic                      out_is_full,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic {
    ST_IDLE,
    ST_READ   // waiting on RAM for the new oldest word
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [WORD_W-1:0]   front_r, front_nxt;
  logic [WORD_W-1:0]   rear_r, rear_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_accepted_r, out_accepted_nxt;
  logic [WORD_W-1:0]   out_front_r, out_front_nxt;
  logic [WORD_W-1:0]   out_rear_r, out_rear_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_full_r, out_full_nxt;

  logic                in_take;
  logic                cfg_wr;
  logic                ok;
  logic                wr_en;
  logic                rd_en;
  logic [WORD_W-1:0]   rd_data;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] slot,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(slot) + 1'b1;
    return (n >= {1'b0, cap}) ? '0 : ADDR_W'(n);
  endfunction

  cqf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_nxt),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_CAPACITY) ? 32'(cap_r) : 32'd0;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_nxt        = state_r;
    cap_nxt          = cap_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    front_nxt        = front_r;
    rear_nxt         = rear_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_accepted_nxt = out_accepted_r;
    out_front_nxt    = out_front_r;
    out_rear_nxt     = out_rear_r;
    out_empty_nxt    = out_empty_r;
    out_full_nxt     = out_full_r;
    ok               = 1'b1;
    wr_en            = 1'b0;
    rd_en            = 1'b0;

    if (cfg_wr) begin
      cap_nxt   = clamp_capacity(pwdata[CAP_W-1:0]);
      head_nxt  = '0;
      tail_nxt  = ADDR_W'(cap_nxt - 1'b1);
      count_nxt = '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (func_t'(in_func))
            FUNC_ENQ: begin
              if (count_r >= cap_r) begin
                ok = 1'b0;
              end else begin
                tail_nxt  = next_slot(tail_r, cap_r);
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                rear_nxt  = in_value;
                if (count_r == '0) front_nxt = in_value;
              end
            end
            FUNC_DEQ: begin
              if (count_r == '0) begin
                ok = 1'b0;
              end else begin
                head_nxt  = next_slot(head_r, cap_r);
                count_nxt = count_r - 1'b1;
                if (count_r != CNT_W'(1)) begin
                  rd_en     = 1'b1;
                  state_nxt = ST_READ;
                end
              end
            end
            default: ;  // status and unused code: no change
          endcase

          if (state_nxt == ST_IDLE) begin
            out_valid_nxt    = 1'b1;
            out_accepted_nxt = ok;
            out_front_nxt    = (count_nxt == '0) ? EMPTY_WORD : front_nxt;
            out_rear_nxt     = (count_nxt == '0) ? EMPTY_WORD : rear_nxt;
            out_empty_nxt    = (count_nxt == '0);
            out_full_nxt     = (count_nxt == cap_r);
          end
        end
      end
      ST_READ: begin
        // queue is known non-empty here
        front_nxt        = rd_data;
        state_nxt        = ST_IDLE;
        out_valid_nxt    = 1'b1;
        out_accepted_nxt = 1'b1;
        out_front_nxt    = rd_data;
        out_rear_nxt     = rear_r;
        out_empty_nxt    = 1'b0;
        out_full_nxt     = (count_r == cap_r);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= clamp_capacity(CAP_RESET);
      head_r      <= '0;
      tail_r      <= ADDR_W'(clamp_capacity(CAP_RESET) - 1'b1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    front_r        <= front_nxt;
    rear_r         <= rear_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_front_r    <= out_front_nxt;
    out_rear_r     <= out_rear_nxt;
    out_empty_r    <= out_empty_nxt;
    out_full_r     <= out_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

  // occupancy never exceeds the configured capacity
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count above capacity");

  // the RAM is never written and read in the same cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("RAM write and read overlap");

  // a pending dequeue never lands on top of an untaken result
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("result register busy during RAM read");

  // an empty result reports all-ones front and rear
  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |->
      (out_front_r == EMPTY_WORD) && (out_rear_r == EMPTY_WORD))
    else $error("empty result with stale words");

  // a read is issued only for a dequeue that leaves entries behind
  a_read_after_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (count_r != '0))
    else $error("RAM read for an empty queue");

endmodule

// File: sv/cqf_ram.sv
// cqf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
